### sv/mbd_pkg.sv
`default_nettype none

package mbd_pkg;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int PIX_W        = 8;
    localparam int SUM_W        = PIX_W + 1;
    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_W       = 3;
    localparam int HEIGHT_W     = 13;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } mbd_ctrl_t;

    localparam int CTRL_W = $bits(mbd_ctrl_t);

    function automatic int col_w(input int max_width);
        return ($clog2(max_width) < 2) ? 2 : $clog2(max_width);
    endfunction

    function automatic int slot_w(input int max_width);
        return col_w(max_width) - 1;
    endfunction

    function automatic int eff_width_w(input int max_width);
        return $clog2(max_width + 1);
    endfunction

endpackage

`default_nettype wire

### sv/mbd_pix_if.sv
`default_nettype none

interface mbd_pix_if;
    import mbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] chan0;
    logic [PIX_W-1:0] chan1;
    logic [PIX_W-1:0] chan2;
    logic [PIX_W-1:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    input ready);
    modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
                  output ready);
endinterface

`default_nettype wire

### sv/mbd_avg_if.sv
`default_nettype none

interface mbd_avg_if;
    import mbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] avg0;
    logic [PIX_W-1:0] avg1;
    logic [PIX_W-1:0] avg2;
    logic [PIX_W-1:0] avg3;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output avg0, output avg1, output avg2, output avg3,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input avg0, input avg1, input avg2, input avg3,
                  input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

### sv/mipmap_box_downsample_2x2_core.sv
// path: an odd-row pair goes through the queue, the line store read stage and the output register; a stall holds it
// throughput: one item per clock while the queue is not full; results pass through the line store read stage
// input stalls only while the four-entry queue is full, which needs the result side to hold off
// reset: counters and channel hold clear, width 1, height 1, all channels enabled
// the line store is not cleared; every entry is written on an even row before it is read
`default_nettype none

module mipmap_box_downsample_2x2_core #(
    parameter int MAX_WIDTH    = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = mbd_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mbd_pix_if.sink                         pix,
    mbd_avg_if.source                       avg,
    input  logic                            write_enable,
    input  logic [mbd_pkg::CFG_INDEX_W-1:0] reg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]  write_data
);
    import mbd_pkg::*;

    localparam int SW = slot_w(MAX_WIDTH);
    localparam int PW = SUM_W * MAX_CHANNELS;
    localparam int QW = CTRL_W + SW + PW;

    logic          push;
    mbd_ctrl_t     push_ctrl;
    logic [SW-1:0] push_slot;
    logic [PW-1:0] push_pair;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_data;
    mbd_ctrl_t     q_ctrl;
    logic [SW-1:0] q_slot;
    logic [PW-1:0] q_pair;

    mbd_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .q_full       (q_full),
        .push         (push),
        .push_ctrl    (push_ctrl),
        .push_slot    (push_slot),
        .push_pair    (push_pair)
    );

    mbd_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctrl, push_slot, push_pair}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign {q_ctrl, q_slot, q_pair} = q_data;

    mbd_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ctrl  (q_ctrl),
        .q_slot  (q_slot),
        .q_pair  (q_pair),
        .q_pop   (q_pop),
        .avg     (avg)
    );

endmodule

`default_nettype wire

### sv/mbd_front.sv
`default_nettype none

module mbd_front #(
    parameter int MAX_WIDTH    = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = mbd_pkg::DEF_MAX_CHANNELS,
    localparam int CW = mbd_pkg::col_w(MAX_WIDTH),
    localparam int SW = mbd_pkg::slot_w(MAX_WIDTH),
    localparam int WW = mbd_pkg::eff_width_w(MAX_WIDTH),
    localparam int PW = mbd_pkg::SUM_W * MAX_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mbd_pix_if.sink                           pix,
    input  logic                              write_enable,
    input  logic [mbd_pkg::CFG_INDEX_W-1:0]   reg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]    write_data,
    input  logic                              q_full,
    output logic                              push,
    output mbd_pkg::mbd_ctrl_t                push_ctrl,
    output logic [SW-1:0]                     push_slot,
    output logic [PW-1:0]                     push_pair
);
    import mbd_pkg::*;

    localparam int HW = PIX_W * MAX_CHANNELS;

    logic [WW-1:0]       width_reg;
    logic [WW-1:0]       width_next;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] height_next;
    logic [CHAN_W-1:0]   chans_reg;
    logic [CHAN_W-1:0]   chans_next;

    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [HW-1:0]       hold_reg;

    logic [NUM_CHANNELS-1:0][PIX_W-1:0] chan_in;
    logic [HW-1:0]       px;
    logic                accept;
    logic                active_row;
    logic                pair_col;
    logic [WW-1:0]       w_even;
    logic [HEIGHT_W-1:0] h_even;
    logic [CW:0]         col_inc;
    logic [HEIGHT_W-1:0] row_inc;

    assign chan_in   = {pix.chan3, pix.chan2, pix.chan1, pix.chan0};
    assign pix.ready = !q_full;
    assign accept    = pix.valid && pix.ready;

    // clamp written values to what the datapath supports
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        chans_next  = chans_reg;
        if (write_enable)
        begin
            unique case (cfg_reg_t'(reg_index))
                CFG_IMAGE_WIDTH:
                begin
                    if (write_data == '0)
                        width_next = WW'(1);
                    else if (int'(write_data) > MAX_WIDTH)
                        width_next = WW'(MAX_WIDTH);
                    else
                        width_next = WW'(write_data);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (write_data == '0)
                        height_next = HEIGHT_W'(1);
                    else if (int'(write_data) > HEIGHT_LIMIT)
                        height_next = HEIGHT_W'(HEIGHT_LIMIT);
                    else
                        height_next = HEIGHT_W'(write_data);
                end
                CFG_CHANNEL_COUNT:
                begin
                    if (write_data[CHAN_W-1:0] == '0)
                        chans_next = CHAN_W'(1);
                    else if (int'(write_data[CHAN_W-1:0]) > MAX_CHANNELS)
                        chans_next = CHAN_W'(MAX_CHANNELS);
                    else
                        chans_next = write_data[CHAN_W-1:0];
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            px[c*PIX_W +: PIX_W] = (CHAN_W'(c) < chans_reg) ? chan_in[c] : '0;
            push_pair[c*SUM_W +: SUM_W] = {1'b0, hold_reg[c*PIX_W +: PIX_W]}
                                        + {1'b0, px[c*PIX_W +: PIX_W]};
        end

        w_even     = width_reg & ~WW'(1);
        h_even     = height_reg & ~HEIGHT_W'(1);
        active_row = HEIGHT_W'(row_reg) < h_even;
        pair_col   = col_reg[0] && (WW'(col_reg) < w_even);

        push                = accept && active_row && pair_col;
        push_slot           = col_reg[CW-1:1];
        push_ctrl.emit      = row_reg[0];
        push_ctrl.row_end   = WW'(col_reg) == (w_even - WW'(1));
        push_ctrl.frame_end = push_ctrl.row_end && (HEIGHT_W'(row_reg) == (h_even - HEIGHT_W'(1)));

        // a counter past a newly written size wraps on its next advance
        col_inc  = {1'b0, col_reg} + (CW+1)'(1);
        row_inc  = HEIGHT_W'(row_reg) + HEIGHT_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= (CW+1)'(width_reg))
            begin
                col_next = '0;
                row_next = (row_inc >= height_reg) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(1);
            height_reg <= HEIGHT_W'(1);
            chans_reg  <= CHAN_W'(MAX_CHANNELS);
            col_reg    <= '0;
            row_reg    <= '0;
            hold_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            chans_reg  <= chans_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            if (accept && active_row && !col_reg[0])
                hold_reg <= px;
        end
    end

`ifndef SYNTHESIS
    a_push_odd_col: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> col_reg[0] && accept)
        else $error("pair issued on an even column");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_ctrl.frame_end |-> push_ctrl.row_end && push_ctrl.emit)
        else $error("frame end without row end on an odd row");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("item pushed into a full queue");
`endif

endmodule

`default_nettype wire

### sv/mbd_queue.sv
`default_nettype none

module mbd_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);
    import mbd_pkg::*;

    logic [DATA_W-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + (QUEUE_PTR_W+1)'(1))
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH) && count_reg != '0
        |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

### sv/mbd_back.sv
`default_nettype none

module mbd_back #(
    parameter int MAX_WIDTH    = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = mbd_pkg::DEF_MAX_CHANNELS,
    localparam int SW = mbd_pkg::slot_w(MAX_WIDTH),
    localparam int PW = mbd_pkg::SUM_W * MAX_CHANNELS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  mbd_pkg::mbd_ctrl_t    q_ctrl,
    input  logic [SW-1:0]         q_slot,
    input  logic [PW-1:0]         q_pair,
    output logic                  q_pop,
    mbd_avg_if.source             avg
);
    import mbd_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    // even-row pair sums, one entry per output column
    logic [PW-1:0] pair_line [LINE_DEPTH];

    logic          valid_a_reg;
    logic          valid_a_next;
    mbd_ctrl_t     ctrl_a_reg;
    logic [PW-1:0] pair_a_reg;
    logic [PW-1:0] line_rd_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    mbd_ctrl_t     out_ctrl_reg;
    logic [NUM_CHANNELS-1:0][PIX_W-1:0] avg_reg;
    logic [NUM_CHANNELS-1:0][PIX_W-1:0] avg_next;
    logic [SUM_W:0] sum4;

    logic          advance_a;
    logic          a_free;
    logic          pop_emit;
    logic          pop_write;

    assign advance_a = valid_a_reg && (!out_valid_reg || avg.ready);
    assign a_free    = !valid_a_reg || advance_a;
    assign q_pop     = q_valid && (!q_ctrl.emit || a_free);
    assign pop_emit  = q_pop && q_ctrl.emit;
    assign pop_write = q_pop && !q_ctrl.emit;

    always_comb
    begin
        valid_a_next = valid_a_reg;
        if (pop_emit)
            valid_a_next = 1'b1;
        else if (advance_a)
            valid_a_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance_a)
            out_valid_next = 1'b1;
        else if (avg.ready)
            out_valid_next = 1'b0;

        avg_next = '0;
        sum4     = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            sum4 = {1'b0, line_rd_reg[c*SUM_W +: SUM_W]} + {1'b0, pair_a_reg[c*SUM_W +: SUM_W]};
            avg_next[c] = sum4[SUM_W:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg   <= valid_a_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_write)
            pair_line[q_slot] <= q_pair;
        if (pop_emit)
        begin
            line_rd_reg <= pair_line[q_slot];
            pair_a_reg  <= q_pair;
            ctrl_a_reg  <= q_ctrl;
        end
        if (advance_a)
        begin
            avg_reg      <= avg_next;
            out_ctrl_reg <= ctrl_a_reg;
        end
    end

    assign avg.valid     = out_valid_reg;
    assign avg.avg0      = avg_reg[0];
    assign avg.avg1      = avg_reg[1];
    assign avg.avg2      = avg_reg[2];
    assign avg.avg3      = avg_reg[3];
    assign avg.row_end   = out_ctrl_reg.row_end;
    assign avg.frame_end = out_ctrl_reg.frame_end;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a_reg && out_valid_reg && !avg.ready |=> valid_a_reg && $stable(pair_a_reg))
        else $error("stalled item lost in read stage");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop_emit |-> !valid_a_reg || advance_a)
        else $error("read stage overwritten");

    a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
        avg.valid && avg.frame_end |-> avg.row_end)
        else $error("frame end without row end");
`endif

endmodule

`default_nettype wire
